FILE: src/group_by_sum_argmax_assert.svh
// ----------------------------------------------------------------------------
// group_by_sum_argmax assertion macros
// concurrent assertion shorthands shared by gbsa_cell and gbsa_out
// ----------------------------------------------------------------------------
`ifndef GROUP_BY_SUM_ARGMAX_ASSERT_SVH
`define GROUP_BY_SUM_ARGMAX_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GBSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbsa assertion failed");

// next-cycle implication
`define GBSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbsa assertion failed");

`else

`define GBSA_ASSERT_IMP(label, ante, cons)
`define GBSA_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: src/gbsa_pkg.sv
// ----------------------------------------------------------------------------
// gbsa_pkg
// types, sizes and arithmetic helpers for the group-by sum / argmax block
// ----------------------------------------------------------------------------
`default_nettype none

package gbsa_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int KEY_BITS      = 64;
  localparam int KEY_W         = 64;
  localparam int SCORE_W       = 32;
  localparam int TOTAL_W       = 64;
  localparam int IN_DATA_W     = ((KEY_W + SCORE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W    = ((KEY_W + TOTAL_W + 7) / 8) * 8;

  typedef logic [KEY_BITS-1:0]       key_t;
  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [TOTAL_W-1:0] total_t;

  // record travelling along the cell row, with the running best of a closing set
  typedef struct packed {
    logic   valid;
    logic   done;
    logic   last;
    key_t   key;
    score_t score;
    logic   best_valid;
    key_t   best_key;
    total_t best_total;
  } tok_t;

  function automatic total_t sext_score(input score_t s);
    return {{(TOTAL_W-SCORE_W){s[SCORE_W-1]}}, s};
  endfunction

  function automatic total_t sat_add(input total_t total, input score_t s);
    logic signed [TOTAL_W:0] sum;
    total_t                  delta;
    delta = sext_score(s);
    sum   = {total[TOTAL_W-1], total} + {delta[TOTAL_W-1], delta};
    if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
      return sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
    end
    return sum[TOTAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/gbsa_cell.sv
// ----------------------------------------------------------------------------
// gbsa_cell
// one table entry: matches, opens or accumulates, and folds the argmax of a
// closing record before clearing itself
// ----------------------------------------------------------------------------
`default_nettype none

`include "group_by_sum_argmax_assert.svh"

module gbsa_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire gbsa_pkg::tok_t tok_i,
  output gbsa_pkg::tok_t     tok_o
);
  import gbsa_pkg::*;

  logic   valid_r, valid_nxt;
  key_t   key_r, key_nxt;
  total_t total_r, total_nxt;
  tok_t   tok_r, tok_nxt;

  logic   hit, open, cur_valid, take;
  total_t sum;

  always_comb begin
    hit       = tok_i.valid && !tok_i.done && valid_r && (key_r == tok_i.key);
    open      = tok_i.valid && !tok_i.done && !valid_r;
    sum       = sat_add(total_r, tok_i.score);
    cur_valid = valid_r || open;
    key_nxt   = open ? tok_i.key : key_r;
    if (hit) begin
      total_nxt = sum;
    end else if (open) begin
      total_nxt = sext_score(tok_i.score);
    end else begin
      total_nxt = total_r;
    end
    take = tok_i.valid && tok_i.last && cur_valid &&
           (!tok_i.best_valid || (total_nxt > tok_i.best_total));

    tok_nxt      = tok_i;
    tok_nxt.done = tok_i.done || hit || open;
    if (take) begin
      tok_nxt.best_valid = 1'b1;
      tok_nxt.best_key   = key_nxt;
      tok_nxt.best_total = total_nxt;
    end

    // closing record empties the entry for the next set
    valid_nxt = (tok_i.valid && tok_i.last) ? 1'b0 : cur_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else if (adv) begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key_r   <= key_nxt;
      total_r <= total_nxt;
    end
  end

  assign tok_o = tok_r;

  `GBSA_ASSERT_NXT(a_close_clears, adv && tok_i.valid && tok_i.last, !valid_r)
  `GBSA_ASSERT_NXT(a_empty_claims, adv && tok_i.valid && !valid_r, tok_r.done)
  `GBSA_ASSERT_NXT(a_close_has_best, adv && tok_i.valid && tok_i.last && valid_r,
                   tok_r.best_valid)

endmodule

`default_nettype wire

FILE: src/gbsa_out.sv
// ----------------------------------------------------------------------------
// gbsa_out
// end of the cell row: overflow tracking, result register and row advance
// ----------------------------------------------------------------------------
`default_nettype none

`include "group_by_sum_argmax_assert.svh"

module gbsa_out (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire gbsa_pkg::tok_t                         tail,
  output logic                                        adv,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [gbsa_pkg::OUT_DATA_W-1:0]             out_tdata,
  output logic                                        out_tuser
);
  import gbsa_pkg::*;

  logic   ovf_r, ovf_nxt;
  logic   vld_r, vld_nxt;
  logic   load, dropped;
  key_t   key_r;
  total_t total_r;
  logic   status_r;

  always_comb begin
    adv     = !(tail.valid && tail.last && vld_r && !out_tready);
    load    = adv && tail.valid && tail.last;
    dropped = tail.valid && !tail.done;
    ovf_nxt = ovf_r;
    if (adv && tail.valid) begin
      ovf_nxt = tail.last ? 1'b0 : (ovf_r || dropped);
    end
    vld_nxt = load || (vld_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      ovf_r <= ovf_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r    <= tail.best_key;
      total_r  <= tail.best_total;
      status_r <= ovf_r || dropped;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {OUT_DATA_W'(total_r) << KEY_W} | OUT_DATA_W'(KEY_W'(key_r));
  assign out_tuser  = status_r;

  `GBSA_ASSERT_NXT(a_close_loads, load, vld_r && !ovf_r)
  `GBSA_ASSERT_IMP(a_close_best, tail.valid && tail.last, tail.best_valid)

endmodule

`default_nettype wire

FILE: src/group_by_sum_argmax.sv
// the closing record passes the TABLE_ENTRIES cell registers and then the result register before out_tvalid
// throughput: one record transaction per cycle while the row is not stalled; each record walks the row of
//   TABLE_ENTRIES cells, one cell per cycle, behind the record before it
// the row stalls only while a finished result waits and the next closing record is due
// reset clears the cell valid bits, the in-flight records, overflow flag and result valid
// ----------------------------------------------------------------------------
// group_by_sum_argmax
// group-by sum with argmax over keyed record sets, built as a row of table cells
// ----------------------------------------------------------------------------
`default_nettype none

module group_by_sum_argmax (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // key, score
  input  wire logic [gbsa_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // best_key, best_total
  output logic [gbsa_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status
  output logic                                out_tuser
);
  import gbsa_pkg::*;

  tok_t chain [TABLE_ENTRIES+1];
  logic adv;

  always_comb begin
    chain[0]            = '0;
    chain[0].valid      = in_tvalid;
    chain[0].last       = in_tlast;
    chain[0].key        = key_t'(in_tdata[KEY_W-1:0]);
    chain[0].score      = in_tdata[KEY_W+SCORE_W-1:KEY_W];
  end

  assign in_tready = adv;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    gbsa_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (chain[i]),
      .tok_o (chain[i+1])
    );
  end

  gbsa_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .tail       (chain[TABLE_ENTRIES]),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
